@@ hw/rtl/xcf_pkg.sv @@
package xcf_pkg;

    // Command codes on i_cmd
    typedef enum logic {
        CMD_START   = 1'b0,
        CMD_PAYLOAD = 1'b1
    } t_cmd;

    localparam logic [7:0] HDR_SOH        = 8'h01;
    localparam logic [7:0] PKT_NUM_RESET  = 8'h01;
    localparam int         PACKET_SIZE_DEF = 128;
    localparam int         RES_CNT_W      = 2;

    localparam logic [RES_CNT_W-1:0] RES_NONE  = 2'd0;
    localparam logic [RES_CNT_W-1:0] RES_ONE   = 2'd1;
    localparam logic [RES_CNT_W-1:0] RES_THREE = 2'd3;

    // Up to three wire bytes caused by one input transfer
    typedef struct packed {
        logic [RES_CNT_W-1:0] count;
        logic [7:0]           byte0;
        logic [7:0]           byte1;
        logic [7:0]           byte2;
        logic                 last2;
    } t_result_set;

    typedef struct packed {
        logic [RES_CNT_W-1:0] count;
        logic                 can_load;
    } t_buf_status;

    // CRC-16/XMODEM, poly 0x1021, MSB first, one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ 16'h1021;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/xcf_core.sv @@
module xcf_core #(
    parameter int PACKET_SIZE = xcf_pkg::PACKET_SIZE_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  logic                 i_cmd,
    input  logic [7:0]           i_header_code,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_data_real,
    output xcf_pkg::t_result_set o_res
);

    localparam int            CW       = $clog2(PACKET_SIZE + 1);
    localparam logic [CW-1:0] LAST_CNT = CW'(PACKET_SIZE - 1);

    logic [7:0]    r_pkt_num, n_pkt_num;
    logic [15:0]   r_crc, n_crc;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_open, n_open;
    logic          r_allow, n_allow;

    logic          is_start;
    logic [7:0]    pay_byte;
    logic [15:0]   crc_upd;
    logic          is_last;

    assign is_start = (xcf_pkg::t_cmd'(i_cmd) == xcf_pkg::CMD_START);
    assign pay_byte = (i_data_real && r_allow) ? i_data_byte : 8'h00;
    assign crc_upd  = xcf_pkg::crc16_byte(r_crc, pay_byte);
    assign is_last  = (r_cnt == LAST_CNT);

    always_comb begin
        n_pkt_num   = r_pkt_num;
        n_crc       = r_crc;
        n_cnt       = r_cnt;
        n_open      = r_open;
        n_allow     = r_allow;
        o_res.count = xcf_pkg::RES_NONE;
        o_res.byte0 = pay_byte;
        o_res.byte1 = crc_upd[15:8];
        o_res.byte2 = crc_upd[7:0];
        o_res.last2 = 1'b0;
        if (is_start) begin
            o_res.count = xcf_pkg::RES_THREE;
            o_res.byte0 = i_header_code;
            o_res.byte1 = r_pkt_num;
            o_res.byte2 = ~r_pkt_num;
            n_pkt_num   = r_pkt_num + 8'd1;
            n_crc       = 16'h0000;
            n_cnt       = '0;
            n_open      = 1'b1;
            n_allow     = (i_header_code == xcf_pkg::HDR_SOH);
        end else if (r_open) begin
            n_crc = crc_upd;
            if (is_last) begin
                o_res.count = xcf_pkg::RES_THREE;
                o_res.last2 = 1'b1;
                n_cnt       = '0;
                n_open      = 1'b0;
            end else begin
                o_res.count = xcf_pkg::RES_ONE;
                n_cnt       = r_cnt + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt_num <= xcf_pkg::PKT_NUM_RESET;
            r_crc     <= 16'h0000;
            r_cnt     <= '0;
            r_open    <= 1'b0;
            r_allow   <= 1'b0;
        end else if (i_take) begin
            r_pkt_num <= n_pkt_num;
            r_crc     <= n_crc;
            r_cnt     <= n_cnt;
            r_open    <= n_open;
            r_allow   <= n_allow;
        end
    end

endmodule

@@ hw/rtl/xcf_out_buf.sv @@
module xcf_out_buf (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  xcf_pkg::t_result_set i_res,
    input  logic                 i_ready,
    output logic                 o_valid,
    output logic [7:0]           o_out_byte,
    output logic                 o_packet_end,
    output xcf_pkg::t_buf_status o_status
);

    logic [7:0]                      r_byte [0:2];
    logic                            r_last [0:2];
    logic [xcf_pkg::RES_CNT_W-1:0]   r_cnt;
    logic                            drain;

    assign o_valid      = (r_cnt != xcf_pkg::RES_NONE);
    assign o_out_byte   = r_byte[0];
    assign o_packet_end = r_last[0];
    assign drain        = o_valid && i_ready;

    // Room for a new set when empty, or once the last held byte leaves this cycle
    assign o_status.count    = r_cnt;
    assign o_status.can_load = (r_cnt == xcf_pkg::RES_NONE) ||
                               ((r_cnt == xcf_pkg::RES_ONE) && i_ready);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_byte[0] <= i_res.byte0;
            r_byte[1] <= i_res.byte1;
            r_byte[2] <= i_res.byte2;
            r_last[0] <= 1'b0;
            r_last[1] <= 1'b0;
            r_last[2] <= i_res.last2;
        end else if (drain) begin
            r_byte[0] <= r_byte[1];
            r_byte[1] <= r_byte[2];
            r_last[0] <= r_last[1];
            r_last[1] <= r_last[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= xcf_pkg::RES_NONE;
        end else if (i_load) begin
            r_cnt <= i_res.count;
        end else if (drain) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

endmodule

@@ hw/rtl/xmodem_crc_packet_framer.sv @@
// XMODEM-CRC packet framer: turns command transfers into packet bytes.
// Input channel (i_valid / o_ready): i_cmd = 0 starts a packet with
//   header i_header_code; i_cmd = 1 carries one payload byte
//   (i_data_byte, zeroed when i_data_real = 0 or the header is not SOH).
// Output channel (o_valid / i_ready): one wire byte per transfer on
//   o_out_byte; o_packet_end marks the CRC low byte.
// A start gives header, packet number, inverted packet number. Each
// payload transfer gives its byte; the PACKET_SIZE-th also gives CRC
// high and low. Payload with no open packet gives nothing.
// The first byte of a result is on the output in the cycle after the
//   input transfer. Throughput: one input transfer per cycle for
//   single-byte results while the receiver is ready; a start or
//   packet-closing transfer holds the 3-byte output buffer, so the
//   next input waits until its last byte drains. The output buffer's
//   one-byte-per-cycle drain, held while i_ready is low, sets the rate.
// Reset (sync, active low): packet number 1, no packet open, output
//   buffer empty. A stalled receiver holds the current byte; input is
//   accepted again once the buffer is down to its last byte and it moves.
module xmodem_crc_packet_framer #(
    parameter int PACKET_SIZE = xcf_pkg::PACKET_SIZE_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_cmd,
    input  logic [7:0] i_header_code,
    input  logic [7:0] i_data_byte,
    input  logic       i_data_real,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_packet_end
);

    xcf_pkg::t_result_set res;
    xcf_pkg::t_buf_status buf_st;
    logic                 take;

    assign o_ready = buf_st.can_load;
    assign take    = i_valid && o_ready;

    // Header/payload decode, packet number, running CRC, byte count
    xcf_core #(
        .PACKET_SIZE(PACKET_SIZE)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_cmd         (i_cmd),
        .i_header_code (i_header_code),
        .i_data_byte   (i_data_byte),
        .i_data_real   (i_data_real),
        .o_res         (res)
    );

    // Three-byte result register, drained one byte per transfer
    xcf_out_buf u_out_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (take),
        .i_res        (res),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_out_byte   (o_out_byte),
        .o_packet_end (o_packet_end),
        .o_status     (buf_st)
    );

    // A start always leaves three bytes queued
    a_start_three: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && (xcf_pkg::t_cmd'(i_cmd) == xcf_pkg::CMD_START)
        |=> o_valid && (buf_st.count == xcf_pkg::RES_THREE))
        else $error("start transfer did not queue three bytes");

    // Packet end only ever sits on the final queued byte
    a_end_is_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_packet_end |-> (buf_st.count == xcf_pkg::RES_ONE))
        else $error("packet end flag not on last queued byte");

    // Input taken only when no queued byte would be overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> (buf_st.count == xcf_pkg::RES_NONE) ||
                 ((buf_st.count == xcf_pkg::RES_ONE) && i_ready))
        else $error("input accepted over undelivered bytes");

endmodule

@@ dv/tb_xmodem_crc_packet_framer.sv @@
module tb_xmodem_crc_packet_framer;
    timeunit 1ns;
    timeprecision 1ps;

    // Full-size packets; only one packet is run to its close, the rest of
    // the traffic is short, abandoned packets and stray payload.
    localparam int PKT_SIZE   = xcf_pkg::PACKET_SIZE_DEF;
    localparam int LONG_HOLD  = 80;       // receiver hold-off, in cycles
    localparam int TAIL_CYC   = 10;       // settle time after the last byte
    localparam int CYC_LIMIT  = 200000;

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports. Every input is known from time zero.
    // ------------------------------------------------------------------
    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic       i_cmd = xcf_pkg::CMD_START;
    logic [7:0] i_header_code = 8'h00;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_data_real = 1'b0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_packet_end;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    xmodem_crc_packet_framer #(
        .PACKET_SIZE (PKT_SIZE)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_cmd         (i_cmd),
        .i_header_code (i_header_code),
        .i_data_byte   (i_data_byte),
        .i_data_real   (i_data_real),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_byte    (o_out_byte),
        .o_packet_end  (o_packet_end)
    );

    // ------------------------------------------------------------------
    // Framer model: tracks the open packet and queues the wire bytes each
    // accepted transfer should put on the output, oldest first.
    // ------------------------------------------------------------------
    typedef struct {
        logic [7:0] wbyte;
        logic       pkt_end;
    } t_wire_byte;

    t_wire_byte  pending_wire_bytes[$];

    logic [7:0]  nxt_pkt_num = xcf_pkg::PKT_NUM_RESET;
    logic [15:0] pkt_crc     = 16'h0000;
    logic [10:0] pkt_bytes   = 11'd0;
    logic        pkt_open    = 1'b0;
    logic        pkt_soh     = 1'b0;    // open packet's header was SOH

    int          n_err = 0;

    // Bit-serial CRC-16/XMODEM, data MSB first
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0} ^ (fb ? 16'h1021 : 16'h0000);
        end
        return c;
    endfunction

    function automatic void queue_wire_byte(input logic [7:0] b, input logic last);
        t_wire_byte w;
        w.wbyte   = b;
        w.pkt_end = last;
        pending_wire_bytes.push_back(w);
    endfunction

    function automatic void frame_transfer(input xcf_pkg::t_cmd cmd, input logic [7:0] hdr,
                                           input logic [7:0] dat, input logic is_real);
        logic [7:0] pay;
        if (cmd == xcf_pkg::CMD_START) begin
            // header, number, inverted number; an open packet is dropped
            queue_wire_byte(hdr, 1'b0);
            queue_wire_byte(nxt_pkt_num, 1'b0);
            queue_wire_byte(~nxt_pkt_num, 1'b0);
            nxt_pkt_num = nxt_pkt_num + 8'd1;
            pkt_crc     = 16'h0000;
            pkt_bytes   = 11'd0;
            pkt_open    = 1'b1;
            pkt_soh     = (hdr == xcf_pkg::HDR_SOH);
        end else if (pkt_open) begin
            // fill positions and non-SOH packets send zero, still CRC'd
            pay     = (is_real && pkt_soh) ? dat : 8'h00;
            pkt_crc = crc_fold(pkt_crc, pay);
            queue_wire_byte(pay, 1'b0);
            pkt_bytes = pkt_bytes + 11'd1;
            if (pkt_bytes >= PKT_SIZE) begin
                queue_wire_byte(pkt_crc[15:8], 1'b0);
                queue_wire_byte(pkt_crc[7:0], 1'b1);
                pkt_open  = 1'b0;
                pkt_bytes = 11'd0;
            end
        end
        // payload with no open packet: nothing on the wire
    endfunction

    // ------------------------------------------------------------------
    // Output checker: every output transfer is matched to the oldest
    // queued wire byte.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_wire_byte w;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_wire_bytes.size() == 0) begin
                $error("unexpected output transfer: out_byte %02h packet_end %0b",
                       o_out_byte, o_packet_end);
                n_err++;
            end else begin
                w = pending_wire_bytes.pop_front();
                if (o_out_byte !== w.wbyte) begin
                    $error("out_byte: expected %02h, actual %02h", w.wbyte, o_out_byte);
                    n_err++;
                end
                if (o_packet_end !== w.pkt_end) begin
                    $error("packet_end: expected %0b, actual %0b", w.pkt_end, o_packet_end);
                    n_err++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, plus one long hold-off on request,
    // counted here so the sender keeps offering transfers meanwhile.
    // ------------------------------------------------------------------
    logic rx_idle_on    = 1'b1;
    logic long_hold_req = 1'b0;
    int   rx_stall_left = 0;

    always @(negedge i_clk) begin
        if (long_hold_req) begin
            long_hold_req = 1'b0;
            rx_stall_left = LONG_HOLD;
        end
        if (rx_stall_left > 0) begin
            i_ready = 1'b0;
            rx_stall_left--;
        end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
            i_ready       = 1'b0;
            rx_stall_left = $urandom_range(1, 13) - 1;
        end else begin
            i_ready = 1'b1;
        end
    end

    // Watchdog
    int cyc_cnt = 0;

    always @(posedge i_clk) begin
        cyc_cnt++;
        if (cyc_cnt >= CYC_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sender. Called at a falling edge; returns at the falling edge after
    // the transfer with i_valid still high, so back-to-back items never
    // drop valid in between.
    // ------------------------------------------------------------------
    logic tx_idle_on = 1'b1;
    int   n_sent = 0;

    task automatic send_item(input xcf_pkg::t_cmd cmd, input logic [7:0] hdr,
                             input logic [7:0] dat, input logic is_real);
        int gap;
        if (tx_idle_on && $urandom_range(0, 4) == 0) begin
            gap     = $urandom_range(1, 13);
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid       = 1'b1;
        i_cmd         = cmd;
        i_header_code = hdr;
        i_data_byte   = dat;
        i_data_real   = is_real;
        do @(posedge i_clk); while (!o_ready);
        frame_transfer(cmd, hdr, dat, is_real);
        n_sent++;
        @(negedge i_clk);
    endtask

    // sender holds off until the wire has caught up with the model
    task automatic wait_drained();
        i_valid = 1'b0;
        while (pending_wire_bytes.size() != 0) @(negedge i_clk);
    endtask

    task automatic send_start(input logic [7:0] hdr);
        send_item(xcf_pkg::CMD_START, hdr, 8'($urandom), 1'($urandom));
    endtask

    task automatic send_payload(input logic [7:0] dat, input logic is_real);
        send_item(xcf_pkg::CMD_PAYLOAD, 8'($urandom), dat, is_real);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Payload transfers with nothing open must be swallowed.
    task automatic test_orphan_payload();
        send_payload(8'hFF, 1'b1);
        send_payload(8'h00, 1'b0);
    endtask

    // Non-SOH headers zero the payload even for real bytes. The first
    // start after reset carries number 1.
    task automatic test_non_soh_header();
        send_start(8'h04);
        for (int i = 0; i < 3; i++) begin
            send_payload(8'hFF, 1'b1);
        end
        send_start(8'hFF);
        send_payload(8'h3C, 1'b1);
    endtask

    // A start mid-packet abandons it; the packet left open here is dropped
    // by the next test's start.
    task automatic test_abandon_packet();
        send_start(8'h00);            // drops the 0xFF packet left open above
        send_start(xcf_pkg::HDR_SOH);
        send_payload(8'h81, 1'b1);
        send_payload(8'h7E, 1'b1);
    endtask

    // Full SOH packet right after an abandoned one: fresh CRC and byte
    // count, extreme bytes and fill positions, closed by the CRC bytes.
    task automatic test_full_soh_packet();
        logic [7:0] pat [4] = '{8'h00, 8'hFF, 8'hA5, 8'h5A};
        send_start(xcf_pkg::HDR_SOH);
        for (int i = 0; i < PKT_SIZE; i++) begin
            send_payload(pat[i % 4], (i % 4) != 2);
        end
    endtask

    // Long receiver hold-off while the sender keeps pushing: the output
    // buffer fills and o_ready must drop until the receiver resumes.
    task automatic test_backpressure();
        tx_idle_on    = 1'b0;
        long_hold_req = 1'b1;
        send_start(xcf_pkg::HDR_SOH);
        send_payload(8'($urandom), 1'b1);
        send_payload(8'($urandom), 1'b1);
        send_start(xcf_pkg::HDR_SOH);
        send_payload(8'($urandom), 1'b1);
        tx_idle_on = 1'b1;
        wait_drained();
    endtask

    // Short packets with random content and odd headers, mixed with
    // random single transfers.
    task automatic test_random_traffic(input int n_items);
        int stop_at;
        int len;
        stop_at = n_sent + n_items;
        while (n_sent < stop_at) begin
            if ($urandom_range(0, 3) != 0) begin
                send_start(($urandom_range(0, 5) != 0) ? xcf_pkg::HDR_SOH : 8'($urandom));
                len = $urandom_range(0, 4);
                for (int i = 0; i < len; i++) begin
                    send_payload(8'($urandom), $urandom_range(0, 7) != 0);
                end
            end else begin
                send_item(xcf_pkg::t_cmd'($urandom_range(0, 1)), 8'($urandom),
                          8'($urandom), 1'($urandom));
            end
        end
    endtask

    // Closing stretch with no idling on either side.
    task automatic test_full_rate();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        send_start(xcf_pkg::HDR_SOH);
        for (int i = 0; i < 6; i++) begin
            send_payload(8'($urandom), 1'($urandom));
        end
        send_start(8'h04);
        send_start(xcf_pkg::HDR_SOH);
        send_payload(8'($urandom), 1'b1);
        send_payload(8'($urandom), 1'b1);
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_orphan_payload();
        test_non_soh_header();
        test_abandon_packet();
        test_full_soh_packet();
        wait_drained();
        test_backpressure();
        test_random_traffic(10);
        test_full_rate();

        wait_drained();
        repeat (TAIL_CYC) @(negedge i_clk);
        if (n_err == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
